### src/carp_pkg.sv
package carp_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OERR,
    S_OINT,
    S_MSTART,
    S_MWAIT,
    S_OCLAMP,
    S_IERR,
    S_IINT,
    S_ICLAMP,
    S_WRITE
  } carp_state_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_OUTER_KP   = 3'd0;
  localparam logic [2:0] REG_OUTER_KI   = 3'd1;
  localparam logic [2:0] REG_OUTER_KD   = 3'd2;
  localparam logic [2:0] REG_INNER_KP   = 3'd3;
  localparam logic [2:0] REG_INNER_KI   = 3'd4;
  localparam logic [2:0] REG_INNER_KD   = 3'd5;
  localparam logic [2:0] REG_OUTER_MODE = 3'd6;
  localparam logic [2:0] REG_INNER_LIM  = 3'd7;

  // Outer loop modes. The fourth code behaves as plain mode.
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_WRAP  = 2'd1;
  localparam logic [1:0] MODE_LIMIT = 2'd2;

  // PID term being multiplied.
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // Limits and constants in whole units, the wrap edge in tenths; scaled by the fraction width at use.
  localparam longint INTEG_LIMIT       = 25000;
  localparam longint INTEG_LIMIT_TIGHT = 10000;
  localparam longint OUT_LIMIT         = 30000;
  localparam longint OUTER_LIMIT_TIGHT = 2000;
  localparam longint INNER_LIMIT_TIGHT = 10000;
  localparam longint WRAP_TENTHS       = 1799;
  localparam longint FULL_TURN_DEG     = 360;

  // Gain reset values in whole units.
  localparam longint OUTER_KP_RESET = 10;
  localparam longint INNER_KP_RESET = 165;
  localparam longint INNER_KI_NUM   = 3;
  localparam longint INNER_KI_DEN   = 4;

endpackage

### src/cascaded_angle_rate_pid_unit.sv
// Cascaded angle/rate PID controller in signed fixed point with FRAC_BITS
// fraction bits. Each request carries a target angle, a measured angle and a
// measured rate; the outer loop turns the angle error into a rate setpoint and
// the inner loop turns the rate error into a drive value, both returned in one
// result. All six gain products run one after another on a single shared
// 32x17 multiplier that walks the operand in 16-bit slices; NL is the number
// of 16-bit slices of the multiplier operand (2 for FRAC_BITS up to 16). The
// input is stalled while a request is being worked on; a finished result sits
// in the output register and the next request is taken while it waits. Gains
// and modes are to be written through the write port only while the block is
// idle; the block itself does not enforce this.
module cascaded_angle_rate_pid_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] target_angle,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rate_setpoint,
  output logic signed [15:0] drive_value
);

  localparam int XW = (FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32;
  localparam int NL = (XW + 15) / 16;
  localparam int RW = 32 + NL * 16 - FRAC_BITS;
  localparam int DW = RW + 2;

  localparam logic signed [DW-1:0] INT_LIM     = DW'(carp_pkg::INTEG_LIMIT <<< FRAC_BITS);
  localparam logic signed [DW-1:0] INT_LIM_T   =
    DW'(carp_pkg::INTEG_LIMIT_TIGHT <<< FRAC_BITS);
  localparam logic signed [DW-1:0] OUT_LIM     = DW'(carp_pkg::OUT_LIMIT <<< FRAC_BITS);
  localparam logic signed [DW-1:0] OUTER_LIM_T =
    DW'(carp_pkg::OUTER_LIMIT_TIGHT <<< FRAC_BITS);
  localparam logic signed [DW-1:0] INNER_LIM_T =
    DW'(carp_pkg::INNER_LIMIT_TIGHT <<< FRAC_BITS);
  localparam logic signed [DW-1:0] WRAP_EDGE   =
    DW'((carp_pkg::WRAP_TENTHS <<< FRAC_BITS) / 10);
  localparam logic signed [DW-1:0] FULL_TURN   =
    DW'(carp_pkg::FULL_TURN_DEG <<< FRAC_BITS);
  localparam logic signed [DW-1:0] S32_MAX     = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] S32_MIN     = -DW'(64'sd2147483648);

  localparam logic signed [31:0] OUTER_KP_RST =
    32'(carp_pkg::OUTER_KP_RESET <<< FRAC_BITS);
  localparam logic signed [31:0] INNER_KP_RST =
    32'(carp_pkg::INNER_KP_RESET <<< FRAC_BITS);
  localparam logic signed [31:0] INNER_KI_RST =
    32'((carp_pkg::INNER_KI_NUM <<< FRAC_BITS) / carp_pkg::INNER_KI_DEN);

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = v;
    if (v > S32_MAX) t = S32_MAX;
    else if (v < S32_MIN) t = S32_MIN;
    return t[31:0];
  endfunction

  function automatic logic signed [DW-1:0] clampv(input logic signed [DW-1:0] v,
                                                  input logic signed [DW-1:0] lim);
    logic signed [DW-1:0] t;
    t = v;
    if (v > lim) t = lim;
    else if (v < -lim) t = -lim;
    return t;
  endfunction

  carp_pkg::carp_state_t state, state_next;

  // Configuration.
  logic signed [31:0] outer_kp, outer_ki, outer_kd;
  logic signed [31:0] inner_kp, inner_ki, inner_kd;
  logic [1:0]         outer_mode;
  logic               inner_limit_mode;

  // Loop state.
  logic signed [XW-1:0] outer_integral, inner_integral;
  logic signed [31:0]   outer_prev_error, inner_prev_error;

  // Working registers.
  logic signed [31:0]   tgt, meas, rate;
  logic signed [31:0]   err, diff;
  logic signed [DW-1:0] sum, sp;
  logic [1:0]           term;
  logic                 stage;

  logic                 mul_start, mul_done;
  logic signed [31:0]   mul_gain;
  logic signed [XW-1:0] mul_x;
  logic signed [RW-1:0] mul_result;

  logic signed [DW-1:0] raw_err, fold_err, drv_floor;
  logic signed [15:0]   drv_q;
  logic                 slot_free;

  assign slot_free = !out_valid || !out_stall;

  carp_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .gain   (mul_gain),
    .operand(mul_x),
    .done   (mul_done),
    .result (mul_result)
  );

  // Angle error with optional folding across the wrap point.
  always_comb begin
    raw_err  = DW'(tgt) - DW'(meas);
    fold_err = raw_err;
    if (outer_mode == carp_pkg::MODE_WRAP && DW'(tgt) <= WRAP_EDGE &&
        DW'(tgt) >= -WRAP_EDGE) begin
      if (raw_err > WRAP_EDGE) fold_err = raw_err - FULL_TURN;
      else if (raw_err < -WRAP_EDGE) fold_err = raw_err + FULL_TURN;
    end
  end

  // Drive value truncated toward zero: floor, plus one for a negative value
  // with a nonzero fraction.
  always_comb begin
    drv_floor = sum >>> FRAC_BITS;
    drv_q = 16'(drv_floor) + 16'(sum[DW-1] && (sum[FRAC_BITS-1:0] != '0));
  end

  always_comb begin
    unique case (term)
      carp_pkg::TERM_P: begin
        mul_gain = stage ? inner_kp : outer_kp;
        mul_x    = XW'(err);
      end
      carp_pkg::TERM_I: begin
        mul_gain = stage ? inner_ki : outer_ki;
        mul_x    = stage ? inner_integral : outer_integral;
      end
      carp_pkg::TERM_D: begin
        mul_gain = stage ? inner_kd : outer_kd;
        mul_x    = XW'(diff);
      end
      default: begin
        mul_gain = stage ? inner_kp : outer_kp;
        mul_x    = XW'(err);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      carp_pkg::S_IDLE:   if (in_valid) state_next = carp_pkg::S_OERR;
      carp_pkg::S_OERR:   state_next = carp_pkg::S_OINT;
      carp_pkg::S_OINT:   state_next = carp_pkg::S_MSTART;
      carp_pkg::S_MSTART: state_next = carp_pkg::S_MWAIT;
      carp_pkg::S_MWAIT: begin
        if (mul_done) begin
          if (term == carp_pkg::TERM_D)
            state_next = stage ? carp_pkg::S_ICLAMP : carp_pkg::S_OCLAMP;
          else
            state_next = carp_pkg::S_MSTART;
        end
      end
      carp_pkg::S_OCLAMP: state_next = carp_pkg::S_IERR;
      carp_pkg::S_IERR:   state_next = carp_pkg::S_IINT;
      carp_pkg::S_IINT:   state_next = carp_pkg::S_MSTART;
      carp_pkg::S_ICLAMP: state_next = carp_pkg::S_WRITE;
      carp_pkg::S_WRITE:  if (slot_free) state_next = carp_pkg::S_IDLE;
      default:            state_next = carp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != carp_pkg::S_IDLE);
    mul_start = (state == carp_pkg::S_MSTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= carp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_kp         <= OUTER_KP_RST;
      outer_ki         <= '0;
      outer_kd         <= '0;
      inner_kp         <= INNER_KP_RST;
      inner_ki         <= INNER_KI_RST;
      inner_kd         <= '0;
      outer_mode       <= carp_pkg::MODE_WRAP;
      inner_limit_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        carp_pkg::REG_OUTER_KP:   outer_kp         <= wr_data;
        carp_pkg::REG_OUTER_KI:   outer_ki         <= wr_data;
        carp_pkg::REG_OUTER_KD:   outer_kd         <= wr_data;
        carp_pkg::REG_INNER_KP:   inner_kp         <= wr_data;
        carp_pkg::REG_INNER_KI:   inner_ki         <= wr_data;
        carp_pkg::REG_INNER_KD:   inner_kd         <= wr_data;
        carp_pkg::REG_OUTER_MODE: outer_mode       <= wr_data[1:0];
        carp_pkg::REG_INNER_LIM:  inner_limit_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_integral   <= '0;
      outer_prev_error <= '0;
      inner_integral   <= '0;
      inner_prev_error <= '0;
      term             <= carp_pkg::TERM_P;
      stage            <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // The write state loads a new result itself when the slot frees up.
      if (out_valid && !out_stall && state != carp_pkg::S_WRITE) out_valid <= 1'b0;
      unique case (state)
        carp_pkg::S_IDLE: begin
          if (in_valid) begin
            tgt  <= target_angle;
            meas <= measured_angle;
            rate <= measured_rate;
          end
        end
        carp_pkg::S_OERR: err <= sat32(fold_err);
        carp_pkg::S_OINT: begin
          outer_integral   <= XW'(clampv(DW'(outer_integral) + DW'(err), INT_LIM));
          diff             <= sat32(DW'(err) - DW'(outer_prev_error));
          outer_prev_error <= err;
          sum              <= '0;
          term             <= carp_pkg::TERM_P;
          stage            <= 1'b0;
        end
        carp_pkg::S_MSTART: ;
        carp_pkg::S_MWAIT: begin
          if (mul_done) begin
            sum  <= sum + DW'(mul_result);
            term <= term + 2'd1;
          end
        end
        carp_pkg::S_OCLAMP: begin
          sp <= clampv(sum, (outer_mode == carp_pkg::MODE_LIMIT) ? OUTER_LIM_T : OUT_LIM);
        end
        carp_pkg::S_IERR: err <= sat32(sp - DW'(rate));
        carp_pkg::S_IINT: begin
          // The tight limit lies inside the normal one, so one clamp does both.
          inner_integral   <= XW'(clampv(DW'(inner_integral) + DW'(err),
                                         inner_limit_mode ? INT_LIM_T : INT_LIM));
          diff             <= sat32(DW'(err) - DW'(inner_prev_error));
          inner_prev_error <= err;
          sum              <= '0;
          term             <= carp_pkg::TERM_P;
          stage            <= 1'b1;
        end
        carp_pkg::S_ICLAMP: begin
          sum <= clampv(sum, inner_limit_mode ? INNER_LIM_T : OUT_LIM);
        end
        carp_pkg::S_WRITE: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            rate_setpoint <= sp[31:0];
            drive_value   <= drv_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/carp_mul.sv
// Shared multiplier: gain times operand, exact, then floored by FRAC_BITS.
// The operand is taken in 16-bit slices from the top down, one 32x17 product
// per slice, accumulated in Horner form.
module carp_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [31:0]                     gain,
  input  logic signed [((FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32)-1:0] operand,
  output logic                                   done,
  output logic signed [32 + 16 * ((((FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32)
                        + 15) / 16) - FRAC_BITS - 1:0] result
);

  localparam int XW   = (FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32;
  localparam int NL   = (XW + 15) / 16;
  localparam int PW   = NL * 16;
  localparam int AW   = 32 + PW;
  localparam int CNTW = $clog2(NL);

  logic                   busy;
  logic                   phase;
  logic                   first;
  logic [CNTW-1:0]        cnt;
  logic signed [31:0]     g;
  logic [PW-1:0]          x_sh;
  logic signed [48:0]     prod;
  logic signed [AW-1:0]   acc;
  logic [15:0]            limb;
  logic signed [16:0]     limb_ext;

  // Only the top slice carries the sign; the lower slices are unsigned.
  assign limb     = x_sh[PW-1 -: 16];
  assign limb_ext = {first & limb[15], limb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        first <= 1'b1;
        cnt   <= CNTW'(NL - 1);
        g     <= gain;
        x_sh  <= PW'(operand);
      end else if (busy) begin
        if (!phase) begin
          prod  <= g * limb_ext;
          x_sh  <= x_sh << 16;
          phase <= 1'b1;
        end else begin
          acc   <= first ? AW'(prod) : (acc <<< 16) + AW'(prod);
          first <= 1'b0;
          phase <= 1'b0;
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

  assign result = acc[AW-1:FRAC_BITS];

endmodule

### src/carp_checker.sv
module carp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] rate_setpoint,
  input logic signed [15:0] drive_value
);

  // A result waiting on a stalled output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_value) &&
    $stable(rate_setpoint))
    else $error("result changed while stalled");

  // One request at a time: the input closes right after a request is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // A new result appears exactly when the block opens for the next request.
  a_result_on_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while busy");

  // The drive value never leaves the output limit.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_value <= 16'sd30000 && drive_value >= -16'sd30000)
    else $error("drive value out of range");

endmodule

bind cascaded_angle_rate_pid_unit carp_checker u_carp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .rate_setpoint(rate_setpoint),
  .drive_value  (drive_value)
);
